@@ hw/rtl/hbs_pkg.sv @@
// Shared types, constants and helper functions for the histogram bin statistics block.
`default_nettype none

package hbs_pkg;

  // Store geometry.
  localparam int unsigned LEVELS     = 256;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned IDX_W      = $clog2(LEVELS);
  localparam int unsigned TOT_W      = COUNT_BITS + IDX_W;

  // Fixed field widths of the beats.
  localparam int unsigned OUT_CNT_W = 24;
  localparam int unsigned OUT_LVL_W = 8;
  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = {OUT_CNT_W{1'b1}};
  localparam logic [OUT_LVL_W-1:0] OUT_LVL_MAX = {OUT_LVL_W{1'b1}};

  // Command queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_CLEAR  = 2'd3
  } hbs_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MED,
    ST_DONE
  } hbs_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  level;
    logic [23:0] count;
  } hbs_in_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] bin_value;
    logic [OUT_CNT_W-1:0] max_count;
    logic [OUT_CNT_W-1:0] average_count;
    logic [OUT_LVL_W-1:0] median_level;
  } hbs_out_t;

  // Decoded command as it sits in the queue.
  typedef struct packed {
    hbs_req_e              kind;
    logic                  in_range;
    logic [IDX_W-1:0]      idx;
    logic [COUNT_BITS-1:0] count;
  } hbs_cmd_t;

  function automatic logic [OUT_CNT_W-1:0] sat_cnt(input logic [63:0] v);
    if (v > 64'(OUT_CNT_MAX)) return OUT_CNT_MAX;
    return v[OUT_CNT_W-1:0];
  endfunction

  function automatic logic [OUT_LVL_W-1:0] sat_lvl(input logic [63:0] v);
    if (v > 64'(OUT_LVL_MAX)) return OUT_LVL_MAX;
    return v[OUT_LVL_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hbs_front.sv @@
// Front end: accepts request beats and decodes them into queue commands.
`default_nettype none

module hbs_front
  import hbs_pkg::*;
(
  input  wire logic     valid_i,
  input  wire hbs_in_t  in_i,
  input  wire logic     q_full_i,
  output logic          stall_o,
  output logic          push_o,
  output hbs_cmd_t      cmd_o
);

  assign stall_o = q_full_i;
  assign push_o  = valid_i && !q_full_i;

  // Levels beyond the store are flagged here so that the back end simply
  // drops such writes and returns zero for such reads.
  always_comb begin
    cmd_o.kind     = hbs_req_e'(in_i.req_type);
    cmd_o.in_range = (32'(in_i.level) < LEVELS);
    cmd_o.idx      = IDX_W'(in_i.level);
    cmd_o.count    = COUNT_BITS'(in_i.count);
  end

endmodule

`default_nettype wire

@@ hw/rtl/hbs_queue.sv @@
// Short command queue that decouples the front end from the back end.
`default_nettype none

module hbs_queue
  import hbs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire hbs_cmd_t cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output hbs_cmd_t      cmd_o
);

  hbs_cmd_t         entry_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QAW:0]     fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == (QAW+1)'(QDEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hbs_back.sv @@
// Back end: bin store, statistics walk and the output register.
`default_nettype none

module hbs_back
  import hbs_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_empty_i,
  input  wire hbs_cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output hbs_out_t      out_data_o
);

  hbs_state_e state_q, state_d;

  // Bin store with per-entry valid bits; an entry that is not valid reads as zero.
  logic [COUNT_BITS-1:0] mem_q [LEVELS];
  logic [LEVELS-1:0]     vld_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rok_q;
  logic [IDX_W-1:0]      pidx_q;
  logic                  pend_q;
  logic [COUNT_BITS-1:0] bin_rd;

  logic [IDX_W:0]        walk_q;
  logic [TOT_W-1:0]      total_q, run_q, run_d;
  logic [COUNT_BITS-1:0] max_q;
  logic [IDX_W-1:0]      med_q;
  logic                  found_q;

  logic                  out_vld_q;
  hbs_out_t              out_q;

  // Control from the output decoder.
  logic             rd_en, rd_ok, wr_en, clr_all;
  logic [IDX_W-1:0] rd_addr;
  logic             start_rep, walk_inc, acc_sum, acc_med, ld_read, ld_rep;
  logic             out_free, issue;

  assign out_free = !out_vld_q || !out_stall_i;
  assign issue    = (walk_q < (IDX_W+1)'(LEVELS));
  assign bin_rd   = rok_q ? rdata_q : '0;
  assign run_d    = run_q + TOT_W'(bin_rd);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (cmd_i.kind)
            REQ_READ:   state_d = ST_READ;
            REQ_REPORT: state_d = ST_SUM;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: if (out_free) state_d = ST_IDLE;
      ST_SUM:  if (!issue && !pend_q) state_d = ST_MED;
      ST_MED:  if (!issue && !pend_q) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    rd_ok     = 1'b0;
    rd_addr   = walk_q[IDX_W-1:0];
    wr_en     = 1'b0;
    clr_all   = 1'b0;
    start_rep = 1'b0;
    walk_inc  = 1'b0;
    acc_sum   = 1'b0;
    acc_med   = 1'b0;
    ld_read   = 1'b0;
    ld_rep    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            REQ_WRITE: wr_en = cmd_i.in_range;
            REQ_READ: begin
              rd_en   = 1'b1;
              rd_addr = cmd_i.idx;
              rd_ok   = cmd_i.in_range && vld_q[cmd_i.idx];
            end
            REQ_REPORT: start_rep = 1'b1;
            REQ_CLEAR:  clr_all = 1'b1;
            default: ;
          endcase
        end
      end
      ST_READ: ld_read = out_free;
      ST_SUM, ST_MED: begin
        rd_en    = issue;
        rd_ok    = issue && vld_q[walk_q[IDX_W-1:0]];
        walk_inc = issue;
        acc_sum  = pend_q && (state_q == ST_SUM);
        acc_med  = pend_q && (state_q == ST_MED);
      end
      ST_DONE: ld_rep = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cmd_i.idx] <= cmd_i.count;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
      pidx_q  <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      rok_q     <= 1'b0;
      pend_q    <= 1'b0;
      walk_q    <= '0;
      total_q   <= '0;
      run_q     <= '0;
      max_q     <= '0;
      med_q     <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (rd_en) begin
        rok_q <= rd_ok;
      end
      if (clr_all) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[cmd_i.idx] <= 1'b1;
      end
      if (start_rep || (state_q == ST_SUM && state_d == ST_MED)) begin
        walk_q <= '0;
      end else if (walk_inc) begin
        walk_q <= walk_q + 1'b1;
      end
      if (start_rep) begin
        total_q <= '0;
        run_q   <= '0;
        max_q   <= '0;
        med_q   <= '0;
        found_q <= 1'b0;
      end
      if (acc_sum) begin
        total_q <= total_q + TOT_W'(bin_rd);
        if (bin_rd > max_q) begin
          max_q <= bin_rd;
        end
      end
      if (acc_med) begin
        run_q <= run_d;
        if (!found_q && (run_d >= (total_q >> 1))) begin
          found_q <= 1'b1;
          med_q   <= pidx_q;
        end
      end
      if (ld_read || ld_rep) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_read) begin
      out_q.bin_value     <= sat_cnt(64'(bin_rd));
      out_q.max_count     <= '0;
      out_q.average_count <= '0;
      out_q.median_level  <= '0;
    end else if (ld_rep) begin
      out_q.bin_value     <= '0;
      out_q.max_count     <= sat_cnt(64'(max_q));
      out_q.average_count <= sat_cnt(64'(total_q / TOT_W'(LEVELS)));
      out_q.median_level  <= sat_lvl(64'(med_q));
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/histogram_bin_statistics.sv @@
// Top level of the histogram bin statistics block.
`default_nettype none

// Channel  Direction  Handshake                  Beat type
// in       input      in_valid_i / in_stall_o    hbs_in_t  (req_type, level, count)
// out      output     out_valid_o / out_stall_i  hbs_out_t (bin_value, max_count,
//                                                average_count, median_level)
//
// A write or a clear is done in the back end's idle state; a read also passes
// through ST_READ after the registered read of the bin store. A report walks
// the store twice, once for the total and the largest count and once for the
// running sum that finds the median, one bin at a time through the single read
// port of the store. The front end keeps taking beats while the two-entry
// command queue has room, even when the back end is busy or a result waits in
// the output register. Reset empties the queue and clears every valid bit of
// the store, so all bins read as zero at once; no clearing pass is needed. A
// stall on the output holds the result register and, once the queue fills,
// reaches the input as in_stall_o.

module histogram_bin_statistics
  import hbs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire hbs_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output hbs_out_t     out_data_o
);

  // Decoded commands travel from the front end through the queue.
  hbs_cmd_t front_cmd;
  hbs_cmd_t head_cmd;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;

  // The front end only decodes; it stalls the input when the queue is full.
  hbs_front u_front (
    .valid_i  (in_valid_i),
    .in_i     (in_data_i),
    .q_full_i (q_full),
    .stall_o  (in_stall_o),
    .push_o   (q_push),
    .cmd_o    (front_cmd)
  );

  hbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  // The back end owns the bin store and the result register; it pops a command
  // only when idle, so a report holds later commands in the queue until done.
  hbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .cmd_i       (head_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
